// File: hdl/mtp_pkg.sv
// Shared types and constants of the majority title picker.
package mtp_pkg;

  // Capacity of the album store and the widths that follow from it.
  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ID_W        = 32;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

  // Result codes.
  typedef enum logic [1:0] {
    CH_NONE   = 2'd0,
    CH_ALBUM  = 2'd1,
    CH_ARTIST = 2'd2,
    CH_MAJOR  = 2'd3
  } choice_e;

  // One input item.
  typedef struct packed {
    logic            entry_live;
    logic [ID_W-1:0] album_key;
    logic [ID_W-1:0] album_artist_key;
    logic [ID_W-1:0] track_artist_id;
    logic            last_entry;
  } mtp_in_t;

  // One result item.
  typedef struct packed {
    choice_e         choice;
    logic [ID_W-1:0] chosen_id;
    logic            entries_dropped;
  } mtp_out_t;

  // Running statistics of the current disc.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  candidate;
    logic [ID_W-1:0]  lead_album;
    logic [ID_W-1:0]  lead_artist;
    logic             uniform_album;
    logic             uniform_artist;
    logic             overflow;
    logic             full;
  } mtp_tally_t;

endpackage

// File: hdl/majority_title_picker.sv
// Top level of the majority title picker: entry intake, recount and result register.
//
// Entries of a disc are taken one per cycle and their album ids are written to an
// on-chip store of MAX_ENTRIES words; entries past that capacity are ignored and
// reported in entries_dropped. The entry marked last closes the disc: the block then
// stalls its input, decides, and delivers one result. When the disc is empty, when a
// common album or common artist settles the choice, or when the vote candidate is
// zero, the result is written in the decision state. Otherwise the vote candidate is
// recounted by reading the stored albums through the store's single read port, one
// word per cycle, while the input stays stalled through the recount and the final
// majority check. A finished result waits in an output register while
// entries of the next disc are already taken; the decision of that next disc waits
// until the register is free.
module majority_title_picker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mtp_pkg::mtp_in_t in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mtp_pkg::mtp_out_t out_item_o
);
  import mtp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_COUNT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  mtp_tally_t       tally;
  logic             accept;
  logic             out_free;
  logic [ID_W-1:0]  album, artist;
  logic             clear;
  logic             wr_en;
  logic             rd_en;
  logic [ID_W-1:0]  rd_data;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ID_W-1:0]  cand_q, cand_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic [CNT_W-1:0] hits_q, hits_d;
  logic             rd_vld_q;
  logic             out_valid_q, out_valid_d;
  mtp_out_t         out_item_q, out_item_d;
  logic             res_wr;
  mtp_out_t         res;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // A dead entry counts as album zero and artist zero.
  always_comb begin
    album  = '0;
    artist = '0;
    if (in_item_i.entry_live) begin
      album  = in_item_i.album_key;
      artist = (in_item_i.album_artist_key != '0) ? in_item_i.album_artist_key
                                                  : in_item_i.track_artist_id;
    end
  end

  mtp_tally u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (accept),
    .clear_i  (clear),
    .album_i  (album),
    .artist_i (artist),
    .tally_o  (tally)
  );

  // Entries below capacity go to the store at the current count.
  assign wr_en = accept && !tally.full;
  assign rd_en = (state_q == ST_COUNT) && (iss_q < cnt_q);

  mtp_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tally.count[ADDR_W-1:0]),
    .wr_data_i (album),
    .rd_en_i   (rd_en),
    .rd_addr_i (iss_q[ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  // Sequencer: decision, recount over the store, final majority check.
  always_comb begin
    state_d = state_q;
    clear   = 1'b0;
    res_wr  = 1'b0;
    res     = '{choice: CH_NONE, chosen_id: '0, entries_dropped: ovf_q};
    cnt_d   = cnt_q;
    cand_d  = cand_q;
    ovf_d   = ovf_q;
    iss_d   = iss_q;
    hits_d  = hits_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_item_i.last_entry) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          clear  = 1'b1;
          cnt_d  = tally.count;
          cand_d = tally.candidate;
          ovf_d  = tally.overflow;
          iss_d  = '0;
          hits_d = '0;
          res.entries_dropped = tally.overflow;
          priority if (tally.count == '0) begin
            res_wr  = 1'b1;
            state_d = ST_IDLE;
          end else if (tally.uniform_album && tally.lead_album != '0) begin
            res.choice    = CH_ALBUM;
            res.chosen_id = tally.lead_album;
            res_wr        = 1'b1;
            state_d       = ST_IDLE;
          end else if (tally.uniform_artist && tally.lead_artist != '0) begin
            res.choice    = CH_ARTIST;
            res.chosen_id = tally.lead_artist;
            res_wr        = 1'b1;
            state_d       = ST_IDLE;
          end else if (tally.candidate != '0) begin
            state_d = ST_COUNT;
          end else begin
            res_wr  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_COUNT: begin
        if (rd_en) begin
          iss_d = iss_q + CNT_W'(1);
        end
        if (rd_vld_q && rd_data == cand_q) begin
          hits_d = hits_q + CNT_W'(1);
        end
        if (!rd_en && !rd_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The output register was free at the decision and stays free.
        res_wr = 1'b1;
        if ({hits_q, 1'b0} > {1'b0, cnt_q}) begin
          res.choice    = CH_MAJOR;
          res.chosen_id = cand_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    priority if (res_wr) begin
      out_valid_d = 1'b1;
      out_item_d  = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      iss_q       <= '0;
      hits_q      <= '0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
      iss_q       <= iss_d;
      hits_q      <= hits_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    cand_q     <= cand_d;
    ovf_q      <= ovf_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: hdl/mtp_ram.sv
// Album store: one write port and one registered read port.
module mtp_ram (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [mtp_pkg::ADDR_W-1:0]  wr_addr_i,
  input  logic [mtp_pkg::ID_W-1:0]    wr_data_i,
  input  logic                        rd_en_i,
  input  logic [mtp_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [mtp_pkg::ID_W-1:0]    rd_data_o
);
  import mtp_pkg::*;

  logic [ID_W-1:0] mem_q [MAX_ENTRIES];
  logic [ID_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/mtp_tally.sv
// Per-disc statistics: first ids, sameness flags and the majority vote.
module mtp_tally (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  logic                     clear_i,
  input  logic [mtp_pkg::ID_W-1:0] album_i,
  input  logic [mtp_pkg::ID_W-1:0] artist_i,
  output mtp_pkg::mtp_tally_t      tally_o
);
  import mtp_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] votes_q, votes_d;
  logic [ID_W-1:0]  cand_q, cand_d;
  logic [ID_W-1:0]  lead_album_q, lead_album_d;
  logic [ID_W-1:0]  lead_artist_q, lead_artist_d;
  logic             uniform_album_q, uniform_album_d;
  logic             uniform_artist_q, uniform_artist_d;
  logic             ovf_q, ovf_d;
  logic             full;
  logic             is_first;

  assign full     = (count_q == MAX_COUNT);
  assign is_first = (count_q == '0);

  // Next state for one entry, or a return to the empty disc.
  always_comb begin
    count_d          = count_q;
    votes_d          = votes_q;
    cand_d           = cand_q;
    lead_album_d     = lead_album_q;
    lead_artist_d    = lead_artist_q;
    uniform_album_d  = uniform_album_q;
    uniform_artist_d = uniform_artist_q;
    ovf_d            = ovf_q;
    priority if (clear_i) begin
      count_d          = '0;
      votes_d          = '0;
      cand_d           = '0;
      lead_album_d     = '0;
      lead_artist_d    = '0;
      uniform_album_d  = 1'b1;
      uniform_artist_d = 1'b1;
      ovf_d            = 1'b0;
    end else if (take_i && full) begin
      ovf_d = 1'b1;
    end else if (take_i) begin
      if (is_first) begin
        lead_album_d  = album_i;
        lead_artist_d = artist_i;
      end
      if (!is_first && album_i != lead_album_q) begin
        uniform_album_d = 1'b0;
      end
      if (!is_first && artist_i != lead_artist_q) begin
        uniform_artist_d = 1'b0;
      end
      priority if (votes_q == '0) begin
        cand_d  = album_i;
        votes_d = CNT_W'(1);
      end else if (album_i == cand_q) begin
        votes_d = votes_q + CNT_W'(1);
      end else begin
        votes_d = votes_q - CNT_W'(1);
      end
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q          <= '0;
      votes_q          <= '0;
      cand_q           <= '0;
      lead_album_q     <= '0;
      lead_artist_q    <= '0;
      uniform_album_q  <= 1'b1;
      uniform_artist_q <= 1'b1;
      ovf_q            <= 1'b0;
    end else begin
      count_q          <= count_d;
      votes_q          <= votes_d;
      cand_q           <= cand_d;
      lead_album_q     <= lead_album_d;
      lead_artist_q    <= lead_artist_d;
      uniform_album_q  <= uniform_album_d;
      uniform_artist_q <= uniform_artist_d;
      ovf_q            <= ovf_d;
    end
  end

  assign tally_o = '{
    count:          count_q,
    candidate:      cand_q,
    lead_album:     lead_album_q,
    lead_artist:    lead_artist_q,
    uniform_album:  uniform_album_q,
    uniform_artist: uniform_artist_q,
    overflow:       ovf_q,
    full:           full
  };

endmodule

// File: hdl/mtp_checker.sv
// Port-level checks of the majority title picker and their binding.
module mtp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input mtp_pkg::mtp_in_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mtp_pkg::mtp_out_t out_item_o
);
  import mtp_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // The closing item of a disc makes the block stall its input next cycle.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.last_entry |=> in_stall_o)
    else $error("input not stalled after the last entry");

  // An item that does not close a disc never raises a new result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_item_i.last_entry |=> !$rose(out_valid_o))
    else $error("result raised without a last entry");

  // A result that chooses nothing carries a zero id.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.choice == CH_NONE |-> out_item_o.chosen_id == '0)
    else $error("nonzero id with no choice");

endmodule

bind majority_title_picker mtp_checker u_mtp_checker (.*);

// File: bench/tb_mtp_title_tracker_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the title choice of each disc.
package tb_mtp_title_tracker_pkg;
  import mtp_pkg::*;

  class title_tracker;
    logic [ID_W-1:0] albums_seen [MAX_ENTRIES];
    int unsigned     n_stored;
    logic [ID_W-1:0] cand_album;
    int unsigned     votes;
    logic [ID_W-1:0] first_alb;
    logic [ID_W-1:0] first_art;
    bit              same_alb;
    bit              same_art;
    bit              dropped;
    mtp_out_t        titles_due [$];
    int unsigned     errors;

    function new();
      errors = 0;
      clear_disc();
    endfunction

    // Every per-disc field but the album store returns to its reset value.
    function void clear_disc();
      n_stored   = 0;
      cand_album = '0;
      votes      = 0;
      first_alb  = '0;
      first_art  = '0;
      same_alb   = 1'b1;
      same_art   = 1'b1;
      dropped    = 1'b0;
    endfunction

    // Fold one accepted item into the disc; a last item closes the disc.
    function void note_entry(mtp_in_t it);
      logic [ID_W-1:0] alb;
      logic [ID_W-1:0] art;
      mtp_out_t        title;
      int unsigned     hits;
      if (!it.entry_live) begin
        alb = '0;
        art = '0;
      end else begin
        alb = it.album_key;
        art = (it.album_artist_key != '0) ? it.album_artist_key : it.track_artist_id;
      end

      // Items past capacity are only flagged.
      if (n_stored >= MAX_ENTRIES) begin
        dropped = 1'b1;
      end else begin
        if (n_stored == 0) begin
          first_alb = alb;
          first_art = art;
        end
        if (alb != first_alb) same_alb = 1'b0;
        if (art != first_art) same_art = 1'b0;
        if (votes == 0) begin
          cand_album = alb;
          votes      = 1;
        end else if (alb == cand_album) begin
          votes++;
        end else begin
          votes--;
        end
        albums_seen[n_stored] = alb;
        n_stored++;
      end
      if (!it.last_entry) return;

      // Decide in priority order: common album, common artist, majority album.
      title.choice          = CH_NONE;
      title.chosen_id       = '0;
      title.entries_dropped = dropped;
      if (n_stored != 0) begin
        if (same_alb && first_alb != '0) begin
          title.choice    = CH_ALBUM;
          title.chosen_id = first_alb;
        end else if (same_art && first_art != '0) begin
          title.choice    = CH_ARTIST;
          title.chosen_id = first_art;
        end else if (cand_album != '0) begin
          hits = 0;
          for (int unsigned i = 0; i < n_stored; i++) begin
            if (albums_seen[i] == cand_album) hits++;
          end
          if (hits * 2 > n_stored) begin
            title.choice    = CH_MAJOR;
            title.chosen_id = cand_album;
          end
        end
      end
      titles_due.push_back(title);
      clear_disc();
    endfunction

    // Compare one delivered result with the oldest open disc.
    function void check_title(mtp_out_t got);
      mtp_out_t want;
      if (titles_due.size() == 0) begin
        $error("unexpected result: choice %0d chosen_id %h entries_dropped %0b",
               got.choice, got.chosen_id, got.entries_dropped);
        errors++;
        return;
      end
      want = titles_due.pop_front();
      if (got.choice !== want.choice) begin
        $error("choice: expected %0d, actual %0d", want.choice, got.choice);
        errors++;
      end
      if (got.chosen_id !== want.chosen_id) begin
        $error("chosen_id: expected %h, actual %h", want.chosen_id, got.chosen_id);
        errors++;
      end
      if (got.entries_dropped !== want.entries_dropped) begin
        $error("entries_dropped: expected %0b, actual %0b",
               want.entries_dropped, got.entries_dropped);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return titles_due.size();
    endfunction

    // Any disc still waiting for its result at the end is a failure.
    function void close_run();
      if (titles_due.size() != 0) begin
        $error("%0d results never arrived", titles_due.size());
        errors++;
      end
    endfunction
  endclass

endpackage

// File: bench/tb_majority_title_picker.sv
`timescale 1ns / 1ps
// Top-level testbench of the majority title picker with disc stimulus and result checking.
module tb_majority_title_picker;
  import mtp_pkg::*;
  import tb_mtp_title_tracker_pkg::*;

  logic     clk;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  mtp_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  mtp_out_t out_item;

  title_tracker tracker = new();

  bit          quiet       = 1'b0;
  int unsigned hold_asked  = 0;
  int unsigned hold_served = 0;
  int unsigned items_sent  = 0;

  majority_title_picker u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check delivered items, then choose the next stall value.
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) tracker.check_title(out_item);
      if (hold_left == 0 && hold_served != hold_asked) begin
        hold_served++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 23);
      end
    end
  end

  function automatic mtp_in_t make_entry(bit live, logic [ID_W-1:0] alb,
                                         logic [ID_W-1:0] alb_art,
                                         logic [ID_W-1:0] trk_art, bit last);
    mtp_in_t e;
    e.entry_live       = live;
    e.album_key        = alb;
    e.album_artist_key = alb_art;
    e.track_artist_id  = trk_art;
    e.last_entry       = last;
    return e;
  endfunction

  // Mostly small ids from a pool so that matches happen, with zero and wide values mixed in.
  function automatic logic [ID_W-1:0] rand_id(int unsigned pool);
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom();
      2:       return '1;
      default: return $urandom_range(pool, 1);
    endcase
  endfunction

  // Offer one item, with an occasional idle gap first, and wait until it is taken.
  task automatic send_entry(mtp_in_t it);
    int unsigned gap;
    if (!quiet && $urandom_range(99) < 23) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(5, 2) : 1;
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_entry(it);
    items_sent++;
  endtask

  // One disc of n items; the style steers it toward one kind of decision.
  task automatic send_disc(int unsigned n, int unsigned style);
    logic [ID_W-1:0] base_alb;
    logic [ID_W-1:0] base_art;
    bit              live;
    bit              last;
    mtp_in_t         e;
    base_alb = rand_id(4);
    base_art = rand_id(4);
    for (int unsigned k = 0; k < n; k++) begin
      live = ($urandom_range(15) != 0);
      last = (k == n - 1);
      case (style)
        0: e = make_entry(live, base_alb, rand_id(3), rand_id(3), last);
        1: begin
          if ($urandom_range(1) != 0) begin
            e = make_entry(live, rand_id(3), base_art, rand_id(3), last);
          end else begin
            e = make_entry(live, rand_id(3), '0, base_art, last);
          end
        end
        2: e = make_entry(live, ($urandom_range(4) < 3) ? base_alb : rand_id(5),
                          rand_id(6), rand_id(6), last);
        default: e = make_entry(1'($urandom_range(1)), $urandom(), rand_id(8), $urandom(),
                                last);
      endcase
      send_entry(e);
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Single live entry: common album.
    send_entry(make_entry(1'b1, 32'd5, 32'd7, 32'd8, 1'b1));
    // Single dead entry: ids are forced to zero, nothing is chosen.
    send_entry(make_entry(1'b0, '1, '1, '1, 1'b1));
    // Common artist, taken from the track artist when the album artist is zero.
    send_entry(make_entry(1'b1, 32'd10, 32'd0, 32'd33, 1'b0));
    send_entry(make_entry(1'b1, 32'd11, 32'd33, 32'd44, 1'b1));
    // Strict majority album.
    send_entry(make_entry(1'b1, 32'd3, 32'd1, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd4, 32'd2, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd3, 32'd3, 32'd0, 1'b1));
    // Tie: no strict majority.
    send_entry(make_entry(1'b1, 32'd6, 32'd1, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd7, 32'd2, 32'd0, 1'b1));
    // Majority of album zero picks nothing.
    send_entry(make_entry(1'b1, 32'd0, 32'd1, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd0, 32'd2, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd9, 32'd3, 32'd0, 1'b1));
    // All-ones album and artist ids.
    send_entry(make_entry(1'b1, '1, '1, '0, 1'b0));
    send_entry(make_entry(1'b1, '1, '0, '1, 1'b1));
    // Common album zero falls through to the common artist.
    send_entry(make_entry(1'b1, 32'd0, 32'd5, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd0, 32'd0, 32'd5, 1'b1));
    // Candidate survives the vote but fails the recount.
    send_entry(make_entry(1'b1, 32'd1, 32'd1, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd2, 32'd2, 32'd0, 1'b0));
    send_entry(make_entry(1'b1, 32'd3, 32'd3, 32'd0, 1'b1));

    // A stretch with no idling on either side.
    quiet = 1'b1;
    for (int unsigned d = 0; d < 10; d++) send_disc($urandom_range(12, 1), $urandom_range(3));
    quiet = 1'b0;

    // Full store, then closing items beyond capacity.
    send_disc(MAX_ENTRIES, 2);
    send_disc(MAX_ENTRIES + 1, 0);
    send_disc(MAX_ENTRIES + 44, 3);

    // Long receiver hold-off while short discs keep coming, so the input backs up.
    hold_asked++;
    for (int unsigned d = 0; d < 12; d++) send_disc($urandom_range(4, 1), $urandom_range(3));

    // Random discs, mostly short.
    while (items_sent < 950) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      send_disc(n, $urandom_range(3));
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    tracker.close_run();
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: majority_title_picker.f
hdl/mtp_pkg.sv
hdl/mtp_ram.sv
hdl/mtp_tally.sv
hdl/majority_title_picker.sv
hdl/mtp_checker.sv
bench/tb_mtp_title_tracker_pkg.sv
bench/tb_majority_title_picker.sv
